// File: design/dsgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsgs_pkg - shared types and constants for the dual stepper goal sequencer
// Command word passed from the front end to the back end, result fields,
// the half-step coil table and the step-toward-goal helper.
// ----------------------------------------------------------------------------
package dsgs_pkg;

    localparam int POS_W       = 32;
    localparam int COIL_W      = 8;
    localparam int WAIT_W      = 16;
    localparam int ELAPSED_W   = 22;
    localparam int DEF_SUBSTEPS = 8;
    localparam logic [WAIT_W-1:0] WAIT_RESET = 16'd1000;

    // Command queue between front and back, depth is a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input kind codes
    localparam logic REQ_GOAL = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Motor select codes
    localparam logic MOTOR_A = 1'b0;
    localparam logic MOTOR_B = 1'b1;

    typedef struct packed {
        logic             is_tick;
        logic             motor_sel;
        logic [POS_W-1:0] goal;
    } cmd_t;

    typedef struct packed {
        logic [ELAPSED_W-1:0] elapsed_us;
        logic [POS_W-1:0]     goal_b;
        logic [POS_W-1:0]     goal_a;
        logic [POS_W-1:0]     position_b;
        logic [POS_W-1:0]     position_a;
        logic [COIL_W-1:0]    coil_bits;
        logic                 stepped;
        logic                 last;
    } result_t;

    // Half-step coil pattern, indexed by position mod 8
    function automatic logic [3:0] half_step(input logic [2:0] idx);
        logic [3:0] pat;
        case (idx)
            3'd0:    pat = 4'h7;
            3'd1:    pat = 4'h3;
            3'd2:    pat = 4'hb;
            3'd3:    pat = 4'h9;
            3'd4:    pat = 4'hd;
            3'd5:    pat = 4'hc;
            3'd6:    pat = 4'he;
            3'd7:    pat = 4'h6;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

    // One step of pos toward goal, signed compare
    function automatic logic [POS_W-1:0] step_toward(input logic [POS_W-1:0] pos,
                                                     input logic [POS_W-1:0] goal);
        logic [POS_W-1:0] res;
        if ($signed(pos) < $signed(goal))
            res = pos + POS_W'(1);
        else if ($signed(pos) > $signed(goal))
            res = pos - POS_W'(1);
        else
            res = pos;
        return res;
    endfunction

endpackage

// File: design/dsgs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsgs_front - input word intake and command queue
// Accepts input words, sorts them into goal writes and ticks, and holds
// them in a short queue for the back end.
// ----------------------------------------------------------------------------
module dsgs_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [dsgs_pkg::POS_W-1:0] s_tdata,
    input  logic [1:0]               s_tuser,
    output logic                     cmd_valid,
    output dsgs_pkg::cmd_t           cmd,
    input  logic                     cmd_pop
);
    import dsgs_pkg::*;

    cmd_t               queue_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               push;
    logic               pop;
    cmd_t               in_cmd;

    assign s_tready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = queue_mem[rd_ptr_reg];

    always_comb
    begin
        in_cmd.is_tick   = (s_tuser[0] == REQ_TICK);
        in_cmd.motor_sel = s_tuser[1];
        in_cmd.goal      = s_tdata;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            queue_mem[wr_ptr_reg] <= in_cmd;
    end

endmodule

// File: design/dsgs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsgs_back - goal/position state and substep sequencer
// Pops commands, updates goals, runs the substeps of a frame tick and
// loads one result per cycle into the output register while it is free or being read.
// ----------------------------------------------------------------------------
module dsgs_back #(
    parameter int SUBSTEPS = dsgs_pkg::DEF_SUBSTEPS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [dsgs_pkg::WAIT_W-1:0] cfg_wr_data,
    input  logic                       cmd_valid,
    input  dsgs_pkg::cmd_t             cmd,
    output logic                       cmd_pop,
    output logic                       res_valid,
    output dsgs_pkg::result_t          res,
    input  logic                       res_ready
);
    import dsgs_pkg::*;

    localparam int CNT_W = (SUBSTEPS > 1) ? $clog2(SUBSTEPS) : 1;

    logic [POS_W-1:0]   goal_a_reg, goal_a_next;
    logic [POS_W-1:0]   goal_b_reg, goal_b_next;
    logic [POS_W-1:0]   pos_a_reg, pos_a_next;
    logic [POS_W-1:0]   pos_b_reg, pos_b_next;
    logic [COIL_W-1:0]  coil_latch_reg, coil_latch_next;
    logic [WAIT_W-1:0]  wait_reg;
    logic               busy_reg, busy_next;
    logic [CNT_W-1:0]   sub_cnt_reg, sub_cnt_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic               can_load;
    logic               at_goal;
    logic               do_sub;
    logic [CNT_W-1:0]   sub_idx;
    logic               fin;
    logic [POS_W-1:0]   step_a, step_b;
    logic [COIL_W-1:0]  coil_new;
    logic [ELAPSED_W-1:0] frame_us;

    assign can_load = !out_valid_reg || res_ready;
    assign at_goal  = (pos_a_reg == goal_a_reg) && (pos_b_reg == goal_b_reg);
    assign cmd_pop  = can_load && !busy_reg && cmd_valid;
    assign do_sub   = can_load && (busy_reg || (cmd_pop && cmd.is_tick && !at_goal));
    assign sub_idx  = busy_reg ? sub_cnt_reg : '0;
    assign fin      = (sub_idx == CNT_W'(SUBSTEPS - 1));
    assign step_a   = step_toward(pos_a_reg, goal_a_reg);
    assign step_b   = step_toward(pos_b_reg, goal_b_reg);
    assign coil_new = {half_step(step_b[2:0]), half_step(step_a[2:0])};
    assign frame_us = ELAPSED_W'(wait_reg) * ELAPSED_W'(SUBSTEPS);

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb
    begin
        goal_a_next     = goal_a_reg;
        goal_b_next     = goal_b_reg;
        pos_a_next      = pos_a_reg;
        pos_b_next      = pos_b_reg;
        coil_latch_next = coil_latch_reg;
        busy_next       = busy_reg;
        sub_cnt_next    = sub_cnt_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !res_ready;

        if (do_sub)
        begin
            pos_a_next      = step_a;
            pos_b_next      = step_b;
            coil_latch_next = coil_new;
            busy_next       = !fin;
            sub_cnt_next    = sub_idx + CNT_W'(1);
            out_valid_next  = 1'b1;
            out_next.coil_bits  = coil_new;
            out_next.position_a = step_a;
            out_next.position_b = step_b;
            out_next.goal_a     = goal_a_reg;
            out_next.goal_b     = goal_b_reg;
            out_next.stepped    = 1'b1;
            out_next.elapsed_us = fin ? frame_us : '0;
            out_next.last       = fin;
        end
        else if (cmd_pop)
        begin
            // goal write or a tick with both motors already parked
            if (!cmd.is_tick)
            begin
                if (cmd.motor_sel == MOTOR_B)
                    goal_b_next = cmd.goal;
                else
                    goal_a_next = cmd.goal;
            end
            out_valid_next      = 1'b1;
            out_next.coil_bits  = coil_latch_reg;
            out_next.position_a = pos_a_reg;
            out_next.position_b = pos_b_reg;
            out_next.goal_a     = goal_a_next;
            out_next.goal_b     = goal_b_next;
            out_next.stepped    = 1'b0;
            out_next.elapsed_us = '0;
            out_next.last       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_a_reg     <= '0;
            goal_b_reg     <= '0;
            pos_a_reg      <= '0;
            pos_b_reg      <= '0;
            coil_latch_reg <= '0;
            wait_reg       <= WAIT_RESET;
            busy_reg       <= 1'b0;
            sub_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            goal_a_reg     <= goal_a_next;
            goal_b_reg     <= goal_b_next;
            pos_a_reg      <= pos_a_next;
            pos_b_reg      <= pos_b_next;
            coil_latch_reg <= coil_latch_next;
            busy_reg       <= busy_next;
            sub_cnt_reg    <= sub_cnt_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
                wait_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

`ifndef ASSERT_OFF
    // No command leaves the queue while a frame is mid-sequence
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !cmd_pop)
        else $error("command popped during a frame");

    // A pending non-final substep result implies the frame is still running
    a_mid_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.stepped && !out_reg.last) |-> busy_reg)
        else $error("non-final substep without active frame");

    // Results that did not step are single, final and carry no time
    a_plain_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.stepped) |-> (out_reg.last && out_reg.elapsed_us == '0))
        else $error("non-stepping result malformed");

    // A goal write pop shows up as a final result on the next cycle
    a_goal_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && !cmd.is_tick) |=> (out_valid_reg && out_reg.last && !out_reg.stepped))
        else $error("goal write result missing");
`endif

endmodule

// File: design/dual_stepper_goal_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_stepper_goal_sequencer - two-motor half-step goal sequencer
// Takes goal writes and frame ticks, steps both motors toward their goals
// and streams out coil bytes with position and goal read-back.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream (s_*): one word per request. s_tuser[0] is the kind
//    (0 goal write, 1 frame tick), s_tuser[1] the motor for a goal write.
//    s_tdata carries the signed goal, ignored on ticks.
//  - Output stream (m_*): goal writes and parked ticks give one word with
//    m_tlast set; a tick with a motor away from goal gives SUBSTEPS words,
//    one per cycle unless stalled, the last with m_tlast and frame time in elapsed_us.
//  - cfg_wr_en/cfg_wr_data load the per-substep wait; write only when idle.
//  - An accepted word is written into the command queue, then popped by
//    the sequencer, which loads its result into the output register.
//  - Throughput: one input word per cycle for goal writes and parked ticks
//    unless stalled; a stepping tick occupies the sequencer to its last substep.
//  - A 2-deep command queue sits between intake and sequencer, so input is
//    still taken while a result waits in the output register.
//  - Stall: when m_tready is low the output register holds; the sequencer
//    stops, the queue fills and s_tready drops.
//  - Reset: goals, positions and coil latch clear, wait returns to 1000 us,
//    queue and output empty.
// ----------------------------------------------------------------------------
module dual_stepper_goal_sequencer #(
    parameter int SUBSTEPS = dsgs_pkg::DEF_SUBSTEPS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // config
    input  logic                        cfg_wr_en,
    input  logic [dsgs_pkg::WAIT_W-1:0] cfg_wr_data,   // step_wait_us
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,       // [31:0] goal_steps
    input  logic [1:0]                  s_tuser,       // [0] req_type, [1] motor_sel
    // output stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [159:0]                m_tdata,       // [7:0] coil_bits,
                                                       // [39:8] position_a,
                                                       // [71:40] position_b,
                                                       // [103:72] goal_a,
                                                       // [135:104] goal_b,
                                                       // [157:136] elapsed_us,
                                                       // [159:158] zero
    output logic                        m_tuser,       // [0] stepped
    output logic                        m_tlast
);
    import dsgs_pkg::*;

    logic     cmd_valid;
    cmd_t     cmd;
    logic     cmd_pop;
    result_t  res;

    dsgs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    dsgs_back #(
        .SUBSTEPS (SUBSTEPS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .res_valid   (m_tvalid),
        .res         (res),
        .res_ready   (m_tready)
    );

    // Pack result fields, lowest field first, padded to whole bytes
    assign m_tdata = {2'b00, res.elapsed_us, res.goal_b, res.goal_a,
                      res.position_b, res.position_a, res.coil_bits};
    assign m_tuser = res.stepped;
    assign m_tlast = res.last;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the dual stepper goal sequencer
// Drives goal writes and frame ticks into the input stream, predicts every
// output word (coil byte, positions, goals, stepped, elapsed time, last) with
// an in-bench model of both motors, and checks each accepted output word
// against the oldest prediction. Covers directed corner cases, several
// step-wait settings, a long output stall and random traffic.
// ----------------------------------------------------------------------------
module tb;
    import dsgs_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_SUB          = DEF_SUBSTEPS;

    // One predicted output word
    typedef struct {
        logic [COIL_W-1:0]    coils;
        logic [POS_W-1:0]     pos_a;
        logic [POS_W-1:0]     pos_b;
        logic [POS_W-1:0]     goal_a;
        logic [POS_W-1:0]     goal_b;
        logic                 stepped;
        logic [ELAPSED_W-1:0] elapsed;
        logic                 last;
    } drive_word_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [WAIT_W-1:0]    cfg_wr_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;
    logic [1:0]           s_tuser = '0;     // [0] req_type, [1] motor_sel
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [159:0]         m_tdata;          // coil, pos a/b, goal a/b, elapsed
    logic                 m_tuser;          // [0] stepped
    logic                 m_tlast;

    // Motor model state
    logic [POS_W-1:0]     mdl_goal [2];
    logic [POS_W-1:0]     mdl_pos [2];
    logic [COIL_W-1:0]    mdl_coils;
    logic [WAIT_W-1:0]    mdl_wait;

    drive_word_t          coil_words_due[$];
    drive_word_t          want;
    int                   errors = 0;
    int                   quiet_cycles = 0;
    int                   hold_cycles = 0;   // receiver hold-off, counted below
    bit                   calm = 1'b0;       // no random idling while set

    // Half-step coil pattern by position mod 8
    logic [3:0]           coil_pattern [8] = '{4'h7, 4'h3, 4'hb, 4'h9,
                                               4'hd, 4'hc, 4'he, 4'h6};

    dual_stepper_goal_sequencer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------------
    // Motor model
    // ------------------------------------------------------------------------

    // One step toward the goal, signed compare, wraps like the hardware
    function automatic logic [POS_W-1:0] nudge(input logic [POS_W-1:0] p,
                                               input logic [POS_W-1:0] g);
        if ($signed(p) < $signed(g))
            return p + 1;
        else if ($signed(p) > $signed(g))
            return p - 1;
        return p;
    endfunction

    function automatic drive_word_t snapshot(input logic stepped,
                                             input logic [ELAPSED_W-1:0] elapsed,
                                             input logic last);
        drive_word_t w;
        w.coils   = mdl_coils;
        w.pos_a   = mdl_pos[MOTOR_A];
        w.pos_b   = mdl_pos[MOTOR_B];
        w.goal_a  = mdl_goal[MOTOR_A];
        w.goal_b  = mdl_goal[MOTOR_B];
        w.stepped = stepped;
        w.elapsed = elapsed;
        w.last    = last;
        return w;
    endfunction

    // Advance the model by one accepted request, queue the words it causes
    task automatic predict_request(input logic kind, input logic sel,
                                   input logic [POS_W-1:0] goal);
        int                   k;
        logic [ELAPSED_W-1:0] el;
        if (kind == REQ_GOAL)
        begin
            mdl_goal[sel] = goal;
            coil_words_due.push_back(snapshot(1'b0, '0, 1'b1));
        end
        else if (mdl_pos[MOTOR_A] == mdl_goal[MOTOR_A] &&
                 mdl_pos[MOTOR_B] == mdl_goal[MOTOR_B])
        begin
            // parked tick: one word, held coils
            coil_words_due.push_back(snapshot(1'b0, '0, 1'b1));
        end
        else
        begin
            for (k = 0; k < N_SUB; k++)
            begin
                mdl_pos[MOTOR_A] = nudge(mdl_pos[MOTOR_A], mdl_goal[MOTOR_A]);
                mdl_pos[MOTOR_B] = nudge(mdl_pos[MOTOR_B], mdl_goal[MOTOR_B]);
                // low three bits give floor mod 8, negative positions too
                mdl_coils = {coil_pattern[mdl_pos[MOTOR_B][2:0]],
                             coil_pattern[mdl_pos[MOTOR_A][2:0]]};
                el = (k == N_SUB - 1) ? ELAPSED_W'(N_SUB * int'(mdl_wait)) : '0;
                coil_words_due.push_back(snapshot(1'b1, el, k == N_SUB - 1));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one request word; entered and left at a falling edge, valid high
    task automatic send_request(input logic kind, input logic sel,
                                input logic [POS_W-1:0] goal);
        int gap;
        if (!calm && $urandom_range(99) < 12)
        begin
            s_tvalid = 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = {sel, kind};
        s_tdata  = goal;
        do
            @(posedge clk);
        while (!s_tready);
        predict_request(kind, sel, goal);
        @(negedge clk);
    endtask

    task automatic send_tick();
        send_request(REQ_TICK, 1'($urandom_range(1)), $urandom());
    endtask

    // Stop offering and wait until every predicted word has been taken
    task automatic drain();
        s_tvalid = 1'b0;
        while (coil_words_due.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Step-wait register, written only while the block is idle
    task automatic write_step_wait(input logic [WAIT_W-1:0] value);
        drain();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        mdl_wait    = value;
    endtask

    // Receiver: random single-cycle holds, or a counted long hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else if (!calm && $urandom_range(99) < 12)
            m_tready <= 1'b0;
        else
            m_tready <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        errors++;
        $display("tb: mismatch %s got %0h want %0h at %0t", what, got, exp_val, $time);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (coil_words_due.size() == 0)
                report_mismatch("unexpected word", m_tdata[31:0], '0);
            else
            begin
                want = coil_words_due.pop_front();
                if (m_tdata[7:0] !== want.coils)
                    report_mismatch("coil_bits", 32'(m_tdata[7:0]), 32'(want.coils));
                if (m_tdata[39:8] !== want.pos_a)
                    report_mismatch("position_a", m_tdata[39:8], want.pos_a);
                if (m_tdata[71:40] !== want.pos_b)
                    report_mismatch("position_b", m_tdata[71:40], want.pos_b);
                if (m_tdata[103:72] !== want.goal_a)
                    report_mismatch("goal_a", m_tdata[103:72], want.goal_a);
                if (m_tdata[135:104] !== want.goal_b)
                    report_mismatch("goal_b", m_tdata[135:104], want.goal_b);
                if (m_tdata[157:136] !== want.elapsed)
                    report_mismatch("elapsed_us", 32'(m_tdata[157:136]),
                                    32'(want.elapsed));
                if (m_tuser !== want.stepped)
                    report_mismatch("stepped", 32'(m_tuser), 32'(want.stepped));
                if (m_tlast !== want.last)
                    report_mismatch("last", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    // Watchdog: too long without a handshake on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Corner cases: parked tick out of reset, goal reached mid-frame,
    // negative positions, goal extremes, fields ignored on ticks
    task automatic test_directed();
        send_request(REQ_TICK, MOTOR_A, 32'h0);            // parked, coils zero
        send_request(REQ_GOAL, MOTOR_A, 32'd5);
        send_request(REQ_GOAL, MOTOR_B, -32'sd3);
        send_request(REQ_TICK, MOTOR_A, 32'h0);            // A stops at 5, B at -3
        send_request(REQ_TICK, MOTOR_B, 32'hffff_ffff);    // parked, held coils
        send_request(REQ_GOAL, MOTOR_A, 32'h7fff_ffff);
        send_request(REQ_GOAL, MOTOR_B, 32'h8000_0000);
        send_request(REQ_TICK, MOTOR_A, 32'h8000_0000);
        send_request(REQ_TICK, MOTOR_B, 32'h7fff_ffff);
        send_request(REQ_GOAL, MOTOR_A, 32'hffff_ffff);
        send_request(REQ_GOAL, MOTOR_B, 32'h0);
        send_request(REQ_TICK, MOTOR_B, 32'h5555_aaaa);
        send_request(REQ_TICK, MOTOR_A, 32'haaaa_5555);
        send_request(REQ_GOAL, MOTOR_A, 32'h0);
        send_request(REQ_TICK, MOTOR_A, 32'h0);
        send_request(REQ_TICK, MOTOR_A, 32'h0);
        send_request(REQ_TICK, MOTOR_B, 32'h0);            // parked again
    endtask

    // Elapsed time at step-wait extremes and a random value
    task automatic test_step_wait();
        logic [WAIT_W-1:0] waits [4];
        int i;
        waits = '{16'd0, 16'hffff, 16'd1, 16'($urandom())};
        for (i = 0; i < 4; i++)
        begin
            write_step_wait(waits[i]);
            send_request(REQ_GOAL, MOTOR_A, mdl_pos[MOTOR_A] + 32'd20);
            send_request(REQ_GOAL, MOTOR_B, mdl_pos[MOTOR_B] - 32'd12);
            send_tick();
            send_tick();
        end
    endtask

    // Long output stall while ticks keep coming, so the input backs up;
    // then the sender waits for every word before going on
    task automatic test_backpressure();
        int i;
        send_request(REQ_GOAL, MOTOR_A, mdl_pos[MOTOR_A] + 32'd1000);
        send_request(REQ_GOAL, MOTOR_B, mdl_pos[MOTOR_B] - 32'd1000);
        @(posedge clk);
        hold_cycles = 300;
        @(negedge clk);
        for (i = 0; i < 24; i++)
            send_tick();
        drain();
    endtask

    // Mostly goals near the current positions plus ticks, with some
    // full-range goals and parking writes for idle ticks
    task automatic test_random_traffic(input int count);
        int               i;
        int               r;
        logic             sel;
        logic [POS_W-1:0] offset;
        for (i = 0; i < count; i++)
        begin
            r      = $urandom_range(99);
            sel    = 1'($urandom_range(1));
            offset = POS_W'($urandom_range(48)) - 32'd24;
            if (r < 48)
                send_tick();
            else if (r < 80)
                send_request(REQ_GOAL, sel, mdl_pos[sel] + offset);
            else if (r < 90)
            begin
                // park both motors, the next tick stays put
                send_request(REQ_GOAL, MOTOR_A, mdl_pos[MOTOR_A]);
                send_request(REQ_GOAL, MOTOR_B, mdl_pos[MOTOR_B]);
            end
            else
                send_request(REQ_GOAL, sel, $urandom());
        end
    endtask

    initial
    begin
        mdl_goal  = '{default: '0};
        mdl_pos   = '{default: '0};
        mdl_coils = '0;
        mdl_wait  = WAIT_RESET;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_step_wait();
        test_backpressure();

        write_step_wait(16'd0);
        test_random_traffic(96);
        write_step_wait(16'hffff);
        calm = 1'b1;                 // stretch with no idling on either side
        test_random_traffic(96);
        calm = 1'b0;
        write_step_wait(16'($urandom()));
        test_random_traffic(96);
        drain();                     // sender pause until all words are out
        write_step_wait(WAIT_RESET);
        test_random_traffic(96);

        drain();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// File: files.f
design/dsgs_pkg.sv
design/dsgs_front.sv
design/dsgs_back.sv
design/dual_stepper_goal_sequencer.sv
tb/tb.sv
